// File: rtl/crf_pkg.sv
// Shared types, constants and arithmetic helpers of the CRF forward recursion block.
`default_nettype none
package crf_pkg;

   localparam int MAX_LABELS_DEF = 64;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int LABEL_W        = 6;
   localparam int VALUE_W        = 32;
   localparam int NLAB_W         = 7;
   localparam logic [NLAB_W-1:0] NLAB_RST = 7'd64;
   localparam int MID_DEPTH      = 4;
   localparam int OUT_DEPTH      = 16;
   localparam int OUT_CNT_W      = $clog2(OUT_DEPTH + 1);
   localparam int CORR_ENTRIES   = 32;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef enum logic {
      KIND_ALPHA = 1'b0,
      KIND_PART  = 1'b1
   } kind_type;

   typedef struct packed {
      logic [LABEL_W-1:0] prev_label;
      logic [LABEL_W-1:0] cur_label;
      value_type          trans_score;
      value_type          state_score;
      logic               first_frame;
      logic               last_frame;
   } req_item_type;

   typedef struct packed {
      kind_type           kind;
      logic [LABEL_W-1:0] label;
      value_type          value;
      logic               last;
   } rsp_item_type;

   // classified item between front and back
   typedef struct packed {
      logic [LABEL_W-1:0] prev_label;
      logic [LABEL_W-1:0] cur_label;
      value_type          trans_score;
      value_type          state_score;
      logic               first_frame;
      logic               last_frame;
      logic               p_first;
      logic               p_last;
      logic               c_first;
      logic               c_last;
      logic               bank;
   } mid_item_type;

   // ln(1+exp(-x)) at x = k/4, Q.16
   localparam logic [15:0] CORR_TAB [CORR_ENTRIES] = '{
      16'd45426, 16'd37745, 16'd31069, 16'd25354, 16'd20530, 16'd16510, 16'd13200, 16'd10500,
      16'd8318,  16'd6567,  16'd5170,  16'd4061,  16'd3184,  16'd2493,  16'd1950,  16'd1523,
      16'd1189,  16'd928,   16'd724,   16'd565,   16'd440,   16'd343,   16'd267,   16'd208,
      16'd162,   16'd126,   16'd98,    16'd77,    16'd60,    16'd47,    16'd36,    16'd28
   };

   function automatic logic signed [VALUE_W:0] ext(input value_type v);
      return {v[VALUE_W-1], v};
   endfunction

   function automatic value_type sat33(input logic signed [VALUE_W:0] v);
      value_type r;
      if (v[VALUE_W] != v[VALUE_W-1]) begin
         r = v[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
      end else begin
         r = v[VALUE_W-1:0];
      end
      return r;
   endfunction

   function automatic value_type max_of(input value_type a, input value_type b);
      return (a > b) ? a : b;
   endfunction

endpackage
`default_nettype wire

// File: rtl/crf_fifo.sv
// Small first-in first-out queue of registers.
`default_nettype none
module crf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire logic [WIDTH-1:0]             push_data,
   output logic                              full,
   input  wire logic                         pop,
   output logic [WIDTH-1:0]                  pop_data,
   output logic                              empty,
   output logic [$clog2(DEPTH+1)-1:0]        count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = data_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// File: rtl/crf_front.sv
// Front end: label count register, range check, classification and read bank tracking.
`default_nettype none
module crf_front #(
   parameter int MAX_LABELS = crf_pkg::MAX_LABELS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_push,
   input  wire crf_pkg::req_item_type        req_data,
   output logic                              req_full,
   input  wire logic                         csr_we,
   input  wire logic [crf_pkg::NLAB_W-1:0]   csr_wdata,
   input  wire logic                         q_full,
   input  wire logic                         clr_busy,
   output logic                              q_push,
   output crf_pkg::mid_item_type             q_data
);
   import crf_pkg::*;

   localparam int CNT_W = $clog2(MAX_LABELS + 1);
   localparam int CMP_W = (CNT_W > NLAB_W) ? CNT_W : NLAB_W;

   logic [NLAB_W-1:0] num_labels_ff;
   logic              bank_ff, bank_in;
   logic [CMP_W-1:0]  nl_ext, n_eff, p_ext, c_ext;
   logic              in_range, accept;

   always_comb begin
      nl_ext = CMP_W'(num_labels_ff);
      if (nl_ext == '0) begin
         n_eff = CMP_W'(1);
      end else if (nl_ext > CMP_W'(MAX_LABELS)) begin
         n_eff = CMP_W'(MAX_LABELS);
      end else begin
         n_eff = nl_ext;
      end
      p_ext    = CMP_W'(req_data.prev_label);
      c_ext    = CMP_W'(req_data.cur_label);
      in_range = (p_ext < n_eff) && (c_ext < n_eff);

      q_data.prev_label  = req_data.prev_label;
      q_data.cur_label   = req_data.cur_label;
      q_data.trans_score = req_data.trans_score;
      q_data.state_score = req_data.state_score;
      q_data.first_frame = req_data.first_frame;
      q_data.last_frame  = req_data.last_frame;
      q_data.p_first     = (p_ext == '0);
      q_data.p_last      = (p_ext == n_eff - CMP_W'(1));
      q_data.c_first     = (c_ext == '0);
      q_data.c_last      = (c_ext == n_eff - CMP_W'(1));
      q_data.bank        = bank_ff;
   end

   // out-of-range items are taken and dropped
   assign req_full = q_full || clr_busy;
   assign accept   = req_push && !req_full;
   assign q_push   = accept && in_range;
   assign bank_in  = (q_push && q_data.p_last && q_data.c_last) ? !bank_ff : bank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_labels_ff <= NLAB_RST;
         bank_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            num_labels_ff <= csr_wdata;
         end
         bank_ff <= bank_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/crf_back.sv
// Back end: alpha memory, log-add accumulators and result generation.
`default_nettype none
module crf_back #(
   parameter int MAX_LABELS = crf_pkg::MAX_LABELS_DEF,
   parameter int FRAC_BITS  = crf_pkg::FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            mid_empty,
   input  wire crf_pkg::mid_item_type           mid_data,
   output logic                                 mid_pop,
   input  wire logic [crf_pkg::OUT_CNT_W-1:0]   out_count,
   output logic                                 out_push,
   output crf_pkg::rsp_item_type                out_data,
   output logic                                 clr_busy
);
   import crf_pkg::*;

   localparam int LBL_W  = $clog2(MAX_LABELS);
   localparam int ADDR_W = LBL_W + 1;
   localparam int NSTG   = 6;
   localparam int SHL    = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int SHR    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam int IDX_LO = FRAC_BITS - 2;
   localparam int BIG_LO = FRAC_BITS + 3;
   localparam int NEED_W = OUT_CNT_W + 2;

   // correction term of a log-add, rescaled to FRAC_BITS
   function automatic value_type corr_of(input value_type a, input value_type b);
      logic signed [VALUE_W:0] diff;
      logic [VALUE_W-1:0]      mag;
      logic [VALUE_W-1:0]      c;
      diff = ext(a) - ext(b);
      mag  = diff[VALUE_W] ? VALUE_W'(-diff) : diff[VALUE_W-1:0];
      c    = (VALUE_W'(CORR_TAB[mag[IDX_LO +: 5]]) << SHL) >> SHR;
      if ((mag >> BIG_LO) != '0) begin
         c = '0;
      end
      return value_type'(c);
   endfunction

   // bank bit on top of the label, so each bank spans a power of two
   logic signed [VALUE_W-1:0] alpha_mem_ff [2**ADDR_W];

   mid_item_type      stg_ff [1:NSTG];
   logic [1:NSTG]     vld_ff;
   value_type         rd_ff, term_ff, m_ff, corr_ff, acc_ff, na_ff, pm_ff, pcorr_ff, part_ff;
   value_type         term_in, m_in, corr_in, acc_in, na_in, pm_in, pcorr_in, part_in;
   logic              clr_busy_ff;
   logic [LBL_W-1:0]  clr_idx_ff;
   logic              hazard, room, issue, alpha_push, part_push, wr_en;
   logic [2:0]        inflight;
   logic [ADDR_W-1:0] rd_addr, wr_addr;

   assign clr_busy = clr_busy_ff;

   // issue control: no issue while the first stage holds an item, no read of a pending write,
   // room for every result still in flight
   always_comb begin
      hazard   = 1'b0;
      inflight = '0;
      for (int k = 1; k < NSTG; k++) begin
         if (vld_ff[k] && stg_ff[k].p_last && (stg_ff[k].bank != mid_data.bank) &&
             (stg_ff[k].cur_label == mid_data.prev_label)) begin
            hazard = 1'b1;
         end
      end
      for (int k = 1; k <= NSTG; k++) begin
         inflight = inflight + 3'(vld_ff[k]);
      end
      room  = (NEED_W'(out_count) + NEED_W'({inflight, 1'b0}) + NEED_W'(2)) <=
              NEED_W'(OUT_DEPTH);
      issue = !mid_empty && !vld_ff[1] && !hazard && room && !clr_busy_ff;
   end

   assign mid_pop = issue;
   assign rd_addr = {mid_data.bank, LBL_W'(mid_data.prev_label)};
   assign wr_addr = {!stg_ff[5].bank, LBL_W'(stg_ff[5].cur_label)};
   assign wr_en   = vld_ff[5] && stg_ff[5].p_last;

   always_comb begin
      term_in  = stg_ff[1].first_frame ? stg_ff[1].trans_score :
                 sat33(ext(rd_ff) + ext(stg_ff[1].trans_score));
      m_in     = stg_ff[2].p_first ? term_ff : max_of(acc_ff, term_ff);
      corr_in  = stg_ff[2].p_first ? '0 : corr_of(acc_ff, term_ff);
      acc_in   = sat33(ext(m_ff) + ext(corr_ff));
      na_in    = sat33(ext(acc_ff) + ext(stg_ff[4].state_score));
      pm_in    = stg_ff[5].c_first ? na_ff : max_of(part_ff, na_ff);
      pcorr_in = stg_ff[5].c_first ? '0 : corr_of(part_ff, na_ff);
      part_in  = sat33(ext(pm_ff) + ext(pcorr_ff));
   end

   assign alpha_push = wr_en;
   assign part_push  = vld_ff[6] && stg_ff[6].p_last && stg_ff[6].c_last &&
                       stg_ff[6].last_frame;
   assign out_push   = alpha_push || part_push;

   always_comb begin
      if (part_push) begin
         out_data.kind  = KIND_PART;
         out_data.label = '0;
         out_data.value = part_in;
         out_data.last  = 1'b1;
      end else begin
         out_data.kind  = KIND_ALPHA;
         out_data.label = stg_ff[5].cur_label;
         out_data.value = na_ff;
         out_data.last  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         acc_ff      <= '0;
         part_ff     <= '0;
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         vld_ff <= {issue, vld_ff[1:NSTG-1]};
         if (vld_ff[3]) begin
            acc_ff <= acc_in;
         end
         if (vld_ff[6] && stg_ff[6].p_last) begin
            part_ff <= part_in;
         end
         if (clr_busy_ff) begin
            if (clr_idx_ff == LBL_W'(MAX_LABELS - 1)) begin
               clr_busy_ff <= 1'b0;
            end
            clr_idx_ff <= clr_idx_ff + LBL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         stg_ff[1] <= mid_data;
      end
      for (int k = 2; k <= NSTG; k++) begin
         stg_ff[k] <= stg_ff[k-1];
      end
      term_ff <= term_in;
      m_ff    <= m_in;
      corr_ff <= corr_in;
      na_ff   <= na_in;
      if (wr_en) begin
         pm_ff    <= pm_in;
         pcorr_ff <= pcorr_in;
      end
   end

   // alpha memory: bank 0 is cleared after reset; bank 1 must be written before use, which the block does not enforce
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         alpha_mem_ff[{1'b0, clr_idx_ff}] <= '0;
      end else if (wr_en) begin
         alpha_mem_ff[wr_addr] <= na_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_ff <= alpha_mem_ff[rd_addr];
      end
   end

`ifndef SYNTH
   a_issue_spacing: assert property (@(posedge clock) disable iff (reset)
      issue |=> !issue)
      else $error("items issued in consecutive cycles");
   a_no_result_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !out_push)
      else $error("result produced during clearing pass");
   a_out_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (out_count != OUT_CNT_W'(OUT_DEPTH)))
      else $error("result queue overflow");
   a_part_after_alpha: assert property (@(posedge clock) disable iff (reset)
      part_push |-> $past(alpha_push))
      else $error("partition not preceded by its last alpha");
`endif

endmodule
`default_nettype wire

// File: rtl/crf_log_forward_recursion.sv
// Top level of the log-domain linear-chain CRF forward recursion block.
//
//  channel   direction  handshake             payload
//  req_      in         req_push / req_full   req_item_type (label pair, scores, frame flags)
//  rsp_      out        rsp_pop / rsp_empty   rsp_item_type (kind, label, value, last)
//  csr_      in         csr_we                csr_wdata: num_labels, no read-back
//
// Issue is spaced by the accumulator log-add loop (max, difference and table lookup
// registered into m_ff and corr_ff, then add and saturate into acc_ff): no new item
// issues while the first stage holds one. A partition follows its frame's last alpha.
// Reset: a clearing pass over bank 0 of the alpha memory, with req_full high.
// Items are held back when the result queue lacks room for the results in flight, or
// when an item reads an alpha still on its way to memory (small label counts).
// Out-of-range items are taken and dropped.
`default_nettype none
module crf_log_forward_recursion #(
   parameter int MAX_LABELS = crf_pkg::MAX_LABELS_DEF,
   parameter int FRAC_BITS  = crf_pkg::FRAC_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_push,
   input  wire crf_pkg::req_item_type        req_data,
   output logic                              req_full,
   output logic                              rsp_empty,
   input  wire logic                         rsp_pop,
   output crf_pkg::rsp_item_type             rsp_data,
   input  wire logic                         csr_we,
   input  wire logic [crf_pkg::NLAB_W-1:0]   csr_wdata
);
   import crf_pkg::*;

   // front -> queue
   logic         q_push, q_full;
   mid_item_type q_data;
   // queue -> back
   logic         mid_pop, mid_empty;
   mid_item_type mid_data;
   // back -> result queue
   logic                 out_push;
   rsp_item_type         out_data;
   logic [OUT_CNT_W-1:0] out_count;
   logic                 clr_busy;

   crf_front #(
      .MAX_LABELS (MAX_LABELS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .clr_busy  (clr_busy),
      .q_push    (q_push),
      .q_data    (q_data)
   );

   // short decoupling queue between classification and execution
   crf_fifo #(
      .WIDTH ($bits(mid_item_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_q (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (mid_pop),
      .pop_data  (mid_data),
      .empty     (mid_empty),
      .count     ()
   );

   crf_back #(
      .MAX_LABELS (MAX_LABELS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (mid_data),
      .mid_pop   (mid_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_data  (out_data),
      .clr_busy  (clr_busy)
   );

   // result queue: the back reserves room before issue, so it never overflows
   crf_fifo #(
      .WIDTH ($bits(rsp_item_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty),
      .count     (out_count)
   );

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the log-domain CRF forward recursion block.
`timescale 1ns / 100ps

module tb_top;
   import crf_pkg::*;

   localparam int LABELS        = MAX_LABELS_DEF;
   localparam int FRAC          = FRAC_BITS_DEF;
   localparam int GEN_VIEW      = 0;     // copy of the state the stimulus builder keeps
   localparam int ACC_VIEW      = 1;     // copy advanced on accepted items
   localparam int SETTLE_CYCLES = 32;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int MAX_REPORTS   = 10;

   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;

   localparam value_type SCORE_MAX = 32'sh7fff_ffff;
   localparam value_type SCORE_MIN = 32'sh8000_0000;
   localparam value_type ONE_Q     = 32'sh0001_0000;

   // ln(1+exp(-x)) sampled at x = k/4, Q.16
   localparam int LN_CORR [32] = '{
      45426, 37745, 31069, 25354, 20530, 16510, 13200, 10500,
      8318,  6567,  5170,  4061,  3184,  2493,  1950,  1523,
      1189,  928,   724,   565,   440,   343,   267,   208,
      162,   126,   98,    77,    60,    47,    36,    28
   };

   // ---------------------------------------------------------------------------------
   // Clock, reset and block inputs (all known from time zero)
   // ---------------------------------------------------------------------------------
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_push  = 1'b0;
   req_item_type      req_data  = '0;
   logic              req_full;
   logic              rsp_empty;
   logic              rsp_pop   = 1'b0;
   rsp_item_type      rsp_data;
   logic              csr_we    = 1'b0;
   logic [NLAB_W-1:0] csr_wdata = '0;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   crf_log_forward_recursion i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------------------
   // Forward recursion predictor: two independent copies of the block's state
   // ---------------------------------------------------------------------------------
   logic [NLAB_W-1:0] labels_cfg [2];
   value_type         alpha_a    [2][LABELS];
   value_type         alpha_b    [2][LABELS];
   bit                b_written  [2][LABELS];
   bit                bank_sel   [2];
   value_type         label_acc  [2];
   value_type         part_acc   [2];

   function automatic value_type clip32(input longint v);
      longint r;
      r = v;
      if (r > SAT_HI) r = SAT_HI;
      if (r < SAT_LO) r = SAT_LO;
      return r[31:0];
   endfunction

   // max plus table correction of the distance, zero from 8.0 upward
   function automatic value_type log_sum(input value_type a, input value_type b);
      longint hi;
      longint diff;
      longint idx;
      longint bump;
      hi   = (a > b) ? longint'(a) : longint'(b);
      diff = (a > b) ? longint'(a) - longint'(b) : longint'(b) - longint'(a);
      idx  = diff >> (FRAC - 2);
      bump = (idx >= 32) ? 0 : longint'(LN_CORR[int'(idx)]);
      return clip32(hi + bump);
   endfunction

   function automatic int active_labels(input int v);
      int n;
      n = int'(labels_cfg[v]);
      if (n < 1) n = 1;
      if (n > LABELS) n = LABELS;
      return n;
   endfunction

   function automatic bit in_range(input int v, input req_item_type it);
      return (int'(it.prev_label) < active_labels(v)) && (int'(it.cur_label) < active_labels(v));
   endfunction

   // would this item read an entry of the second bank that was never written?
   function automatic bit reads_unwritten(input int v, input req_item_type it);
      return in_range(v, it) && !it.first_frame && bank_sel[v] && !b_written[v][it.prev_label];
   endfunction

   task automatic clear_view(input int v);
      labels_cfg[v] = NLAB_RST;
      for (int i = 0; i < LABELS; i++) begin
         alpha_a[v][i]   = '0;
         alpha_b[v][i]   = '0;
         b_written[v][i] = 1'b0;
      end
      bank_sel[v]  = 1'b0;
      label_acc[v] = '0;
      part_acc[v]  = '0;
   endtask

   // advance one copy by one item; returns how many results it causes
   function automatic int forward_step(input int v, input req_item_type it,
                                       output rsp_item_type r0, output rsp_item_type r1);
      int        n;
      int        p;
      int        c;
      value_type prev;
      value_type term;
      value_type na;
      int        cnt;
      n   = active_labels(v);
      p   = int'(it.prev_label);
      c   = int'(it.cur_label);
      r0  = '0;
      r1  = '0;
      cnt = 0;
      if (p < n && c < n) begin
         if (it.first_frame) prev = '0;
         else prev = bank_sel[v] ? alpha_b[v][p] : alpha_a[v][p];
         term = clip32(longint'(prev) + longint'(it.trans_score));
         label_acc[v] = (p == 0) ? term : log_sum(label_acc[v], term);
         if (p == n - 1) begin
            na = clip32(longint'(label_acc[v]) + longint'(it.state_score));
            if (bank_sel[v]) begin
               alpha_a[v][c] = na;
            end else begin
               alpha_b[v][c]   = na;
               b_written[v][c] = 1'b1;
            end
            r0.kind  = KIND_ALPHA;
            r0.label = it.cur_label;
            r0.value = na;
            r0.last  = 1'b0;
            cnt = 1;
            part_acc[v] = (c == 0) ? na : log_sum(part_acc[v], na);
            if (c == n - 1) begin
               bank_sel[v] = !bank_sel[v];
               if (it.last_frame) begin
                  r1.kind  = KIND_PART;
                  r1.label = '0;
                  r1.value = part_acc[v];
                  r1.last  = 1'b1;
                  cnt = 2;
               end
            end
         end
      end
      return cnt;
   endfunction

   // ---------------------------------------------------------------------------------
   // Shared bookkeeping
   // ---------------------------------------------------------------------------------
   req_item_type pending_items [$];   // built by the stimulus, drained by the driver
   rsp_item_type due_results   [$];   // predicted results in arrival order
   int  queued_cnt   = 0;
   int  taken_cnt    = 0;
   int  live_cnt     = 0;             // items the block does not ignore
   int  alpha_cnt    = 0;
   int  part_cnt     = 0;
   int  err_cnt      = 0;
   int  cfg_writes   = 0;
   int  cycle_cnt    = 0;
   bit  req_taken    = 1'b0;
   bit  rsp_taken    = 1'b0;
   int  send_gap     = 0;
   int  pop_gap      = 0;
   bit  send_burst   = 1'b0;
   bit  pop_burst    = 1'b0;

   // ---------------------------------------------------------------------------------
   // Rising edge: handshake detection, checking of results, prediction of new ones.
   // Results are compared before the accepted item is predicted; an item's results
   // are never on the port at the edge that takes it.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : edge_sample
      rsp_item_type want;
      rsp_item_type p0;
      rsp_item_type p1;
      int           k;
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_cnt, due_results.size());
         $display("[crf_log_forward_recursion] ERROR");
         $finish;
      end else if (reset) begin
         req_taken = 1'b0;
         rsp_taken = 1'b0;
      end else begin
         rsp_taken = rsp_pop && !rsp_empty;
         if (rsp_taken) begin
            if (due_results.size() == 0) begin
               err_cnt++;
               if (err_cnt <= MAX_REPORTS)
                  $display("unexpected result: kind %0d label %0d value %h last %0d",
                           rsp_data.kind, rsp_data.label, rsp_data.value, rsp_data.last);
            end else begin
               want = due_results.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.label !== want.label ||
                   rsp_data.value !== want.value || rsp_data.last !== want.last) begin
                  err_cnt++;
                  if (err_cnt <= MAX_REPORTS)
                     $display("mismatch: expected kind %0d label %0d value %h last %0d, %s",
                              want.kind, want.label, want.value, want.last,
                              $sformatf("got kind %0d label %0d value %h last %0d",
                                        rsp_data.kind, rsp_data.label, rsp_data.value,
                                        rsp_data.last));
               end
            end
            if (rsp_data.kind == KIND_PART) part_cnt++;
            else alpha_cnt++;
         end
         req_taken = req_push && !req_full;
         if (req_taken) begin
            k = forward_step(ACC_VIEW, req_data, p0, p1);
            if (k > 0) due_results.push_back(p0);
            if (k > 1) due_results.push_back(p1);
            taken_cnt++;
         end
         if (csr_we) labels_cfg[ACC_VIEW] = csr_wdata;
      end
   end

   // ---------------------------------------------------------------------------------
   // Driver: presents pending items at the falling edge, with a random gap after each one
   // and occasional runs without gaps.
   // ---------------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_push <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_data <= pending_items.pop_front();
            req_push <= 1'b1;
            if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, 8);
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Result side: pop held high until an item is taken, then a random stall
   // ---------------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (!rsp_pop || rsp_taken) begin
         if (pop_gap > 0) begin
            pop_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if ($urandom_range(0, 39) == 0) pop_burst = !pop_burst;
            pop_gap = pop_burst ? 0 : $urandom_range(0, 8);
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------
   // mostly small scores so that the correction table is exercised, some full range
   // and some at the saturation points
   function automatic value_type rand_score();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0: return SCORE_MAX;
               1: return SCORE_MIN;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      endcase
   endfunction

   // queue one item; an item that would read a never-written bank entry is turned
   // into a first-frame item instead
   task automatic queue_item(input int p, input int c, input value_type t, input value_type s,
                             input bit ff, input bit lf);
      req_item_type it;
      rsp_item_type d0;
      rsp_item_type d1;
      int           k;
      it.prev_label  = p[LABEL_W-1:0];
      it.cur_label   = c[LABEL_W-1:0];
      it.trans_score = t;
      it.state_score = s;
      it.first_frame = ff;
      it.last_frame  = lf;
      if (reads_unwritten(GEN_VIEW, it)) it.first_frame = 1'b1;
      if (in_range(GEN_VIEW, it)) live_cnt++;
      k = forward_step(GEN_VIEW, it, d0, d1);
      pending_items.push_back(it);
      queued_cnt++;
   endtask

   // well-formed frames, current label outer; cut >= 0 breaks the sequence off
   task automatic queue_sequence(input int n, input int frames, input int cut);
      bit fresh;
      int idx;
      fresh = ($urandom_range(0, 3) != 0);
      idx   = 0;
      for (int f = 0; f < frames; f++)
         for (int c = 0; c < n; c++)
            for (int p = 0; p < n; p++) begin
               if (cut >= 0 && idx >= cut) return;
               queue_item(p, c, rand_score(), rand_score(), fresh && f == 0, f == frames - 1);
               idx++;
            end
   endtask

   // wait until every item is taken and every result has come, then let the
   // pipeline empty of items that cause no result
   task automatic drain();
      while (queued_cnt != taken_cnt || due_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_labels(input int v);
      drain();
      csr_wdata <= v[NLAB_W-1:0];
      csr_we    <= 1'b1;
      labels_cfg[GEN_VIEW] = v[NLAB_W-1:0];
      cfg_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------
   initial begin : stimulus
      int plan [12];
      int n;
      int target;
      int start;
      int sel;
      plan = '{3, 1, 127, 4, 0, 2, 64, 6, 100, 8, 5, 7};
      clear_view(GEN_VIEW);
      clear_view(ACC_VIEW);
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed, reset label count of 64: saturation both ways, partition at the
      // top label, accumulator restart, read of a written second-bank entry
      queue_item(63, 0,  SCORE_MAX, SCORE_MAX, 1'b1, 1'b0);
      queue_item(63, 63, SCORE_MIN, SCORE_MIN, 1'b1, 1'b1);
      queue_item(0,  17, ONE_Q, '0, 1'b1, 1'b0);
      queue_item(63, 17, -ONE_Q, '1, 1'b1, 1'b0);
      queue_item(63, 5,  '0, '0, 1'b0, 1'b0);

      // two labels: equal terms, distance just under 8.0
      write_labels(2);
      queue_item(0, 0, '0, ONE_Q, 1'b1, 1'b0);
      queue_item(1, 0, '0, ONE_Q, 1'b1, 1'b0);
      queue_item(0, 1, 32'sh0007_ffff, '0, 1'b1, 1'b0);
      queue_item(1, 1, '0, '0, 1'b1, 1'b0);
      queue_item(0, 0, 32'sh0008_0000, -ONE_Q, 1'b0, 1'b1);
      queue_item(1, 0, '0, '0, 1'b0, 1'b1);
      queue_item(0, 1, 32'sh0000_4000, SCORE_MAX, 1'b0, 1'b1);
      queue_item(1, 1, -32'sh0000_4000, '0, 1'b0, 1'b1);
      // labels out of range are dropped
      queue_item(2, 0,  ONE_Q, ONE_Q, 1'b0, 1'b1);
      queue_item(0, 63, ONE_Q, ONE_Q, 1'b0, 1'b1);

      // zero clamps to a single label
      write_labels(0);
      queue_item(0, 0, SCORE_MAX, ONE_Q, 1'b1, 1'b1);
      queue_item(1, 0, ONE_Q, ONE_Q, 1'b1, 1'b1);

      // random phases; a phase may end mid-sequence so the next label count picks up
      // a half-finished recursion. Each change of setting waits for every result.
      foreach (plan[i]) begin
         write_labels(plan[i]);
         n      = active_labels(GEN_VIEW);
         target = (n > 8) ? 50 : 150;
         start  = live_cnt;
         while (live_cnt - start < target) begin
            if (n > 8) begin
               // large counts: whole frames are too long, so hit the top label often
               queue_item($urandom_range(0, 1) ? 63 : $urandom_range(0, 63),
                          $urandom_range(0, 63), rand_score(), rand_score(),
                          $urandom_range(0, 3) != 0, $urandom_range(0, 1));
            end else begin
               sel = $urandom_range(0, 19);
               if (sel < 14) begin
                  queue_sequence(n, $urandom_range(1, 4), -1);
               end else if (sel < 17) begin
                  queue_sequence(n, $urandom_range(1, 3), $urandom_range(0, n * n * 2));
               end else begin
                  repeat ($urandom_range(1, 6))
                     queue_item($urandom_range(0, 1) ? $urandom_range(0, n - 1)
                                                     : $urandom_range(0, 63),
                                $urandom_range(0, 1) ? $urandom_range(0, n - 1)
                                                     : $urandom_range(0, 63),
                                rand_score(), rand_score(),
                                $urandom_range(0, 1), $urandom_range(0, 1));
               end
            end
         end
      end

      drain();
      $display("%0d items sent (%0d within the label count), %0d label-count writes",
               taken_cnt, live_cnt, cfg_writes);
      $display("%0d alpha and %0d partition results checked, %0d failures",
               alpha_cnt, part_cnt, err_cnt);
      if (err_cnt == 0) begin
         $display("[crf_log_forward_recursion] OK");
      end else begin
         $display("[crf_log_forward_recursion] ERROR");
      end
      $finish;
   end

endmodule
